// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion shorthands used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SRWA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SRWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/srwa_pkg.sv =====
package srwa_pkg;

   localparam int FAST_DEPTH_DEF = 64;
   localparam int MID_DEPTH_DEF  = 64;
   localparam int SLOW_DEPTH_DEF = 64;

   localparam int NUM_RINGS  = 3;
   localparam int SPEED_W    = 16;
   localparam int TICK_W     = 16;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 22;
   localparam int WINDOW_W   = 16;
   localparam int AVG_W      = 16;

   localparam int REQ_DATA_W = SPEED_W + TIME_W;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = NUM_RINGS * AVG_W;
   localparam int RSP_USER_W = NUM_RINGS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = INTERVAL_W;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFE;

   // floor(x / 1000) == (x * TICK_MAGIC) >> TICK_SHIFT for every 32-bit x
   localparam int TICK_MAGIC_W = 29;
   localparam logic [TICK_MAGIC_W-1:0] TICK_MAGIC = 29'd274877907;
   localparam int TICK_SHIFT = 38;

   localparam logic [REQ_USER_W-1:0] MODE_ADD       = 1'b0;
   localparam logic [REQ_USER_W-1:0] MODE_RECOMPUTE = 1'b1;

   localparam logic [1:0] RING_FAST = 2'd0;
   localparam logic [1:0] RING_MID  = 2'd1;
   localparam logic [1:0] RING_SLOW = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_INTERVAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_INTERVAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_WINDOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_WINDOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_WINDOW   = 3'd5;

   localparam logic [INTERVAL_W-1:0] FAST_INTERVAL_RST = 22'd1000;
   localparam logic [INTERVAL_W-1:0] MID_INTERVAL_RST  = 22'd5000;
   localparam logic [INTERVAL_W-1:0] SLOW_INTERVAL_RST = 22'd30000;
   localparam logic [WINDOW_W-1:0]   FAST_WINDOW_RST   = 16'd60;
   localparam logic [WINDOW_W-1:0]   MID_WINDOW_RST    = 16'd300;
   localparam logic [WINDOW_W-1:0]   SLOW_WINDOW_RST   = 16'd1800;

   typedef struct packed {
      logic [TICK_W-1:0]  tick;
      logic [SPEED_W-1:0] speed;
   } entry_type;

endpackage

// ===== rtl/core/subsampled_ring_window_average.sv =====
// Add request: the tick multiply, then one ring per cycle, before ready returns.
// Recompute request: each ring in turn is walked and its mean divided;
// the walk reads one ring entry per cycle and the shared divider retires one quotient bit
// per cycle (DVD_W = 25 bits at the default depths). One request is in flight at a time.
// Reset is synchronous, active high: rings empty, heads and take times zero, registers
// at their defaults. Ring memories are not cleared; only written entries are ever read.
module subsampled_ring_window_average #(
   parameter int FAST_DEPTH = srwa_pkg::FAST_DEPTH_DEF,
   parameter int MID_DEPTH  = srwa_pkg::MID_DEPTH_DEF,
   parameter int SLOW_DEPTH = srwa_pkg::SLOW_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [srwa_pkg::REQ_DATA_W-1:0] req_tdata,   // speed_centi, now_ms
   input  logic [srwa_pkg::REQ_USER_W-1:0] req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [srwa_pkg::RSP_DATA_W-1:0] rsp_tdata,   // fast_avg, mid_avg, slow_avg
   output logic [srwa_pkg::RSP_USER_W-1:0] rsp_tuser,   // fast_valid, mid_valid, slow_valid
   input  logic                            csr_we,
   input  logic [srwa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srwa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAX_DEPTH = (FAST_DEPTH > MID_DEPTH) ?
                              ((FAST_DEPTH > SLOW_DEPTH) ? FAST_DEPTH : SLOW_DEPTH) :
                              ((MID_DEPTH > SLOW_DEPTH) ? MID_DEPTH : SLOW_DEPTH);
   localparam int PTR_W   = $clog2(MAX_DEPTH);
   localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
   localparam int FAST_AW = $clog2(FAST_DEPTH);
   localparam int MID_AW  = $clog2(MID_DEPTH);
   localparam int SLOW_AW = $clog2(SLOW_DEPTH);
   localparam int SUM_W   = srwa_pkg::SPEED_W + CNT_W;
   localparam int DVD_W   = SUM_W + 2;
   localparam int DVS_W   = CNT_W + 1;
   localparam int STEP_W  = $clog2(DVD_W);
   localparam int PROD_W  = srwa_pkg::TIME_W + srwa_pkg::TICK_MAGIC_W;
   localparam int NR      = srwa_pkg::NUM_RINGS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_TAKE,
      ST_WINIT,
      ST_WALK,
      ST_DSETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] ring_depth(input logic [1:0] r);
      logic [CNT_W-1:0] d;
      case (r)
         srwa_pkg::RING_FAST: d = CNT_W'(FAST_DEPTH);
         srwa_pkg::RING_MID:  d = CNT_W'(MID_DEPTH);
         srwa_pkg::RING_SLOW: d = CNT_W'(SLOW_DEPTH);
         default:             d = '0;
      endcase
      return d;
   endfunction

   state_type state_ff, state_in;
   logic [1:0] ring_ff, ring_in;

   logic [srwa_pkg::REQ_USER_W-1:0] mode_ff, mode_in;
   logic [srwa_pkg::SPEED_W-1:0]    speed_ff, speed_in;
   logic [srwa_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [srwa_pkg::TICK_W-1:0]     tick_ff, tick_in;

   logic [PTR_W-1:0]               head_ff [NR];
   logic [PTR_W-1:0]               head_in [NR];
   logic [CNT_W-1:0]               count_ff [NR];
   logic [CNT_W-1:0]               count_in [NR];
   logic [srwa_pkg::TIME_W-1:0]    last_ff [NR];
   logic [srwa_pkg::TIME_W-1:0]    last_in [NR];
   logic [srwa_pkg::INTERVAL_W-1:0] interval_ff [NR];
   logic [srwa_pkg::INTERVAL_W-1:0] interval_in [NR];
   logic [srwa_pkg::WINDOW_W-1:0]  window_ff [NR];
   logic [srwa_pkg::WINDOW_W-1:0]  window_in [NR];
   logic [srwa_pkg::AVG_W-1:0]     avg_ff [NR];
   logic [srwa_pkg::AVG_W-1:0]     avg_in [NR];
   logic                           vld_ff [NR];
   logic                           vld_in [NR];

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] num_ff, num_in;

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [srwa_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [srwa_pkg::RSP_USER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   srwa_pkg::entry_type fast_mem [FAST_DEPTH];
   srwa_pkg::entry_type mid_mem [MID_DEPTH];
   srwa_pkg::entry_type slow_mem [SLOW_DEPTH];
   srwa_pkg::entry_type fast_rd_ff, mid_rd_ff, slow_rd_ff;
   srwa_pkg::entry_type rd_entry, wr_entry;
   logic                wr_en;

   logic [PROD_W-1:0]            tick_prod;
   logic [CNT_W-1:0]             depth_r;
   logic [srwa_pkg::TIME_W-1:0]  elapsed;
   logic                         take;
   logic [srwa_pkg::TICK_W-1:0]  age;
   logic                         walk_stop;
   logic [PTR_W-1:0]             ptr_prev;
   logic [DVS_W:0]               rem_sh;
   logic                         qbit;
   logic [DVS_W:0]               rem_diff;
   logic                         last_ring;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign tick_prod = PROD_W'(now_ff) * PROD_W'(srwa_pkg::TICK_MAGIC);
   assign depth_r   = ring_depth(ring_ff);
   assign last_ring = (ring_ff == srwa_pkg::RING_SLOW);

   // interval check on wrapped elapsed time
   assign elapsed = now_ff - last_ff[ring_ff];
   assign take    = (count_ff[ring_ff] == '0) ||
                    (elapsed >= srwa_pkg::TIME_W'(interval_ff[ring_ff]));
   assign wr_entry = '{tick: tick_ff, speed: speed_ff};

   always_comb begin
      case (ring_ff)
         srwa_pkg::RING_FAST: rd_entry = fast_rd_ff;
         srwa_pkg::RING_MID:  rd_entry = mid_rd_ff;
         default:             rd_entry = slow_rd_ff;
      endcase
   end

   assign age       = tick_ff - rd_entry.tick;
   assign walk_stop = pend_ff && (age > window_ff[ring_ff]);
   assign ptr_prev  = (ptr_ff == '0) ? PTR_W'(depth_r - CNT_W'(1)) : ptr_ff - PTR_W'(1);

   // one restoring division step per cycle
   assign rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
   assign qbit     = (rem_sh >= {1'b0, dvs_ff});
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      state_in      = state_ff;
      ring_in       = ring_ff;
      mode_in       = mode_ff;
      speed_in      = speed_ff;
      now_in        = now_ff;
      tick_in       = tick_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      interval_in   = interval_ff;
      window_in     = window_ff;
      avg_in        = avg_ff;
      vld_in        = vld_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      num_in        = num_ff;
      dvd_in        = dvd_ff;
      dvs_in        = dvs_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      wr_en         = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               speed_in = (req_tdata[srwa_pkg::SPEED_W-1:0] > srwa_pkg::SPEED_MAX) ?
                          srwa_pkg::SPEED_MAX : req_tdata[srwa_pkg::SPEED_W-1:0];
               now_in   = req_tdata[srwa_pkg::REQ_DATA_W-1:srwa_pkg::SPEED_W];
               state_in = ST_TICK;
            end
         end
         ST_TICK: begin
            tick_in = tick_prod[srwa_pkg::TICK_SHIFT +: srwa_pkg::TICK_W];
            ring_in = srwa_pkg::RING_FAST;
            state_in = (mode_ff == srwa_pkg::MODE_RECOMPUTE) ? ST_WINIT : ST_TAKE;
         end
         ST_TAKE: begin
            if (take) begin
               wr_en = 1'b1;
               head_in[ring_ff] = (CNT_W'(head_ff[ring_ff]) == depth_r - CNT_W'(1)) ?
                                  '0 : head_ff[ring_ff] + PTR_W'(1);
               if (count_ff[ring_ff] < depth_r) begin
                  count_in[ring_ff] = count_ff[ring_ff] + CNT_W'(1);
               end
               last_in[ring_ff] = now_ff;
            end
            if (last_ring) begin
               state_in = ST_IDLE;
            end else begin
               ring_in = ring_ff + 2'd1;
            end
         end
         ST_WINIT: begin
            // start at the newest entry, one behind the head
            ptr_in   = (head_ff[ring_ff] == '0) ? PTR_W'(depth_r - CNT_W'(1)) :
                       head_ff[ring_ff] - PTR_W'(1);
            idx_in   = '0;
            pend_in  = 1'b0;
            sum_in   = '0;
            num_in   = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_stop) begin
               pend_in  = 1'b0;
               state_in = ST_DSETUP;
            end else begin
               if (pend_ff) begin
                  sum_in = sum_ff + SUM_W'(rd_entry.speed);
                  num_in = num_ff + CNT_W'(1);
               end
               // issue the next read while the previous one is checked
               if (idx_ff < count_ff[ring_ff]) begin
                  pend_in = 1'b1;
                  ptr_in  = ptr_prev;
                  idx_in  = idx_ff + CNT_W'(1);
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     state_in = ST_DSETUP;
                  end
               end
            end
         end
         ST_DSETUP: begin
            if (num_ff >= CNT_W'(2)) begin
               dvd_in   = DVD_W'({sum_ff, 1'b0}) + DVD_W'(num_ff);
               dvs_in   = {num_ff, 1'b0};
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               avg_in[ring_ff] = '0;
               vld_in[ring_ff] = 1'b0;
               if (last_ring) begin
                  state_in = ST_DONE;
               end else begin
                  ring_in  = ring_ff + 2'd1;
                  state_in = ST_WINIT;
               end
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], qbit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               avg_in[ring_ff] = dvd_in[srwa_pkg::AVG_W-1:0];
               vld_in[ring_ff] = 1'b1;
               if (last_ring) begin
                  state_in = ST_DONE;
               end else begin
                  ring_in  = ring_ff + 2'd1;
                  state_in = ST_WINIT;
               end
            end
         end
         ST_DONE: begin
            // hold until the previous response is gone
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {avg_ff[srwa_pkg::RING_SLOW], avg_ff[srwa_pkg::RING_MID],
                                avg_ff[srwa_pkg::RING_FAST]};
               rsp_tuser_in  = {vld_ff[srwa_pkg::RING_SLOW], vld_ff[srwa_pkg::RING_MID],
                                vld_ff[srwa_pkg::RING_FAST]};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            srwa_pkg::CSR_FAST_INTERVAL: interval_in[srwa_pkg::RING_FAST] = csr_wdata;
            srwa_pkg::CSR_MID_INTERVAL:  interval_in[srwa_pkg::RING_MID]  = csr_wdata;
            srwa_pkg::CSR_SLOW_INTERVAL: interval_in[srwa_pkg::RING_SLOW] = csr_wdata;
            srwa_pkg::CSR_FAST_WINDOW:
               window_in[srwa_pkg::RING_FAST] = csr_wdata[srwa_pkg::WINDOW_W-1:0];
            srwa_pkg::CSR_MID_WINDOW:
               window_in[srwa_pkg::RING_MID]  = csr_wdata[srwa_pkg::WINDOW_W-1:0];
            srwa_pkg::CSR_SLOW_WINDOW:
               window_in[srwa_pkg::RING_SLOW] = csr_wdata[srwa_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ring_ff       <= srwa_pkg::RING_FAST;
         rsp_tvalid_ff <= 1'b0;
         for (int r = 0; r < NR; r++) begin
            head_ff[r]  <= '0;
            count_ff[r] <= '0;
            last_ff[r]  <= '0;
         end
         interval_ff[srwa_pkg::RING_FAST] <= srwa_pkg::FAST_INTERVAL_RST;
         interval_ff[srwa_pkg::RING_MID]  <= srwa_pkg::MID_INTERVAL_RST;
         interval_ff[srwa_pkg::RING_SLOW] <= srwa_pkg::SLOW_INTERVAL_RST;
         window_ff[srwa_pkg::RING_FAST]   <= srwa_pkg::FAST_WINDOW_RST;
         window_ff[srwa_pkg::RING_MID]    <= srwa_pkg::MID_WINDOW_RST;
         window_ff[srwa_pkg::RING_SLOW]   <= srwa_pkg::SLOW_WINDOW_RST;
      end else begin
         state_ff      <= state_in;
         ring_ff       <= ring_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         last_ff       <= last_in;
         interval_ff   <= interval_in;
         window_ff     <= window_in;
      end
      mode_ff      <= mode_in;
      speed_ff     <= speed_in;
      now_ff       <= now_in;
      tick_ff      <= tick_in;
      avg_ff       <= avg_in;
      vld_ff       <= vld_in;
      ptr_ff       <= ptr_in;
      idx_ff       <= idx_in;
      pend_ff      <= pend_in;
      sum_ff       <= sum_in;
      num_ff       <= num_in;
      dvd_ff       <= dvd_in;
      dvs_ff       <= dvs_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en && ring_ff == srwa_pkg::RING_FAST) begin
         fast_mem[head_ff[srwa_pkg::RING_FAST][FAST_AW-1:0]] <= wr_entry;
      end
      if (ring_ff == srwa_pkg::RING_FAST) begin
         fast_rd_ff <= fast_mem[ptr_ff[FAST_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && ring_ff == srwa_pkg::RING_MID) begin
         mid_mem[head_ff[srwa_pkg::RING_MID][MID_AW-1:0]] <= wr_entry;
      end
      if (ring_ff == srwa_pkg::RING_MID) begin
         mid_rd_ff <= mid_mem[ptr_ff[MID_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && ring_ff == srwa_pkg::RING_SLOW) begin
         slow_mem[head_ff[srwa_pkg::RING_SLOW][SLOW_AW-1:0]] <= wr_entry;
      end
      if (ring_ff == srwa_pkg::RING_SLOW) begin
         slow_rd_ff <= slow_mem[ptr_ff[SLOW_AW-1:0]];
      end
   end

endmodule

// ===== rtl/core/srwa_checker.sv =====
`include "assert_macros.svh"

module srwa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [srwa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [srwa_pkg::RSP_USER_W-1:0] rsp_tuser
);

   localparam int AW = srwa_pkg::AVG_W;

   // an accepted request keeps the block busy, so ready drops
   `SRWA_ASSERT_NEXT(a_req_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready did not drop after a request was accepted")

   `SRWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

   // an average with fewer than two samples reads as zero
   `SRWA_ASSERT_IMPL(a_invalid_avg_zero, clock, reset, rsp_tvalid, (rsp_tuser[0] || rsp_tdata[AW-1:0] == '0) && (rsp_tuser[1] || rsp_tdata[2*AW-1:AW] == '0) && (rsp_tuser[2] || rsp_tdata[3*AW-1:2*AW] == '0), "average without a valid flag is not zero")

   // stored speeds saturate, so no mean can reach all ones
   `SRWA_ASSERT_IMPL(a_avg_saturated, clock, reset, rsp_tvalid, rsp_tdata[AW-1:0] != '1 && rsp_tdata[2*AW-1:AW] != '1 && rsp_tdata[3*AW-1:2*AW] != '1, "average above the saturated speed")

endmodule

bind subsampled_ring_window_average srwa_checker u_srwa_checker (.*);

// ===== sim/tb_subsampled_ring_window_average.sv =====
`timescale 1ns / 100ps

module tb_subsampled_ring_window_average;
   import srwa_pkg::*;

   localparam int LIMIT_CYCLES  = 3000000;
   localparam int SETTLE_CYCLES = 16;    // outlasts the busy time of an add
   localparam int TAIL_CYCLES   = 400;   // outlasts a full recompute walk
   localparam int DIRECTED_ROWS = 19;
   localparam int MAX_DEPTH     = 255;
   localparam int MS_PER_TICK   = 1000;

   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0]  CSR_SPARE_HI = 3'd7;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 22'd3600000;
   localparam logic [WINDOW_W-1:0]   WINDOW_MAX   = 16'hFFFF;

   typedef struct packed {
      logic             slow_valid;
      logic             mid_valid;
      logic             fast_valid;
      logic [AVG_W-1:0] slow_avg;
      logic [AVG_W-1:0] mid_avg;
      logic [AVG_W-1:0] fast_avg;
   } window_means_t;

   typedef enum logic {CHECK_PREDICTED, CHECK_TYPED} check_kind_t;

   typedef struct packed {
      logic [REQ_USER_W-1:0] mode;
      logic [SPEED_W-1:0]    speed;
      logic [TIME_W-1:0]     now_ms;
      check_kind_t           check;
      window_means_t         typed;
   } stimulus_row_t;

   localparam window_means_t ALL_INVALID    = '0;
   localparam window_means_t FAST_PAIR_FULL = '{fast_avg: 16'hFFFE, fast_valid: 1'b1,
                                                default: '0};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = MODE_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_FAST_INTERVAL;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // ring image kept alongside the block
   logic [SPEED_W-1:0]    kept_speed [NUM_RINGS][MAX_DEPTH];
   logic [TICK_W-1:0]     kept_tick  [NUM_RINGS][MAX_DEPTH];
   int unsigned           ring_head  [NUM_RINGS];
   int unsigned           ring_fill  [NUM_RINGS];
   logic [TIME_W-1:0]     last_take_ms [NUM_RINGS];
   logic [INTERVAL_W-1:0] take_interval [NUM_RINGS];
   logic [WINDOW_W-1:0]   view_window [NUM_RINGS];

   window_means_t         pending_means [$];
   logic [TIME_W-1:0]     stream_ms;
   bit                    idle_bursts = 1'b1;
   int                    stall_left  = 0;
   int                    mismatches  = 0;
   int                    cycle_count = 0;

   stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
      '{MODE_RECOMPUTE, 16'h0000, 32'h0000_0000, CHECK_TYPED,     ALL_INVALID},
      '{MODE_ADD,       16'hFFFF, 32'h0000_0000, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'h0000_0000, CHECK_TYPED,     ALL_INVALID},
      '{MODE_ADD,       16'hFFFE, 32'd1000,      CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'd1000,      CHECK_TYPED,     FAST_PAIR_FULL},
      '{MODE_ADD,       16'h0000, 32'd1999,      CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'h0000, 32'd2000,      CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'h0001, 32'd5000,      CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'hFFFF, 32'd5000,      CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'd61000,     CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'd62000,     CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'd12345, 32'd30000,    CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'h8000, 32'hFFFF_FC18, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'h7FFF, 32'h0000_03E8, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'h0000_03E8, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'hAAAA, 32'h5555_5555, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_ADD,       16'h5555, 32'hAAAA_AAAA, CHECK_PREDICTED, ALL_INVALID},
      '{MODE_RECOMPUTE, 16'h0000, 32'hAAAA_AAAA, CHECK_PREDICTED, ALL_INVALID},
      // same tick modulo 2^16, roughly 18 hours later
      '{MODE_RECOMPUTE, 16'h0000, 32'hAE92_AAAA, CHECK_PREDICTED, ALL_INVALID}
   };

   subsampled_ring_window_average u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned ring_depth(input int r);
      case (r)
         RING_FAST: return FAST_DEPTH_DEF;
         RING_MID:  return MID_DEPTH_DEF;
         default:   return SLOW_DEPTH_DEF;
      endcase
   endfunction

   function automatic logic [TICK_W-1:0] tick_of(input logic [TIME_W-1:0] ms);
      logic [TIME_W-1:0] secs;
      secs = ms / MS_PER_TICK;
      return secs[TICK_W-1:0];
   endfunction

   task automatic take_sample(input int r, input logic [SPEED_W-1:0] speed,
                              input logic [TIME_W-1:0] now_ms);
      logic [TIME_W-1:0] elapsed;
      int unsigned       h;
      elapsed = now_ms - last_take_ms[r];
      if (ring_fill[r] == 0 || elapsed >= take_interval[r]) begin
         h = ring_head[r];
         kept_speed[r][h] = speed;
         kept_tick[r][h]  = tick_of(now_ms);
         ring_head[r]     = (h + 1) % ring_depth(r);
         if (ring_fill[r] < ring_depth(r))
            ring_fill[r]++;
         last_take_ms[r] = now_ms;
      end
   endtask

   function automatic void ring_mean(input int r, input logic [TIME_W-1:0] now_ms,
                                     output logic [AVG_W-1:0] avg, output logic valid);
      logic [TICK_W-1:0] cur;
      logic [TICK_W-1:0] age;
      logic [63:0]       sum;
      int unsigned       n;
      int unsigned       k;
      int unsigned       depth;
      cur   = tick_of(now_ms);
      sum   = '0;
      n     = 0;
      depth = ring_depth(r);
      // walk newest to oldest, stop at the first entry outside the window
      for (int unsigned i = 0; i < ring_fill[r]; i++) begin
         k   = (ring_head[r] + depth - 1 - i) % depth;
         age = cur - kept_tick[r][k];
         if (age > view_window[r])
            break;
         sum += kept_speed[r][k];
         n++;
      end
      if (n >= 2) begin
         avg   = AVG_W'((sum * 2 + n) / (2 * n));
         valid = 1'b1;
      end else begin
         avg   = '0;
         valid = 1'b0;
      end
   endfunction

   task automatic predict_request(input logic [REQ_USER_W-1:0] mode,
                                  input logic [SPEED_W-1:0] speed,
                                  input logic [TIME_W-1:0] now_ms,
                                  output bit produces, output window_means_t means);
      logic [SPEED_W-1:0] stored;
      means    = '0;
      produces = (mode == MODE_RECOMPUTE);
      if (mode == MODE_ADD) begin
         stored = (speed > SPEED_MAX) ? SPEED_MAX : speed;
         for (int r = 0; r < NUM_RINGS; r++)
            take_sample(r, stored, now_ms);
      end else begin
         ring_mean(RING_FAST, now_ms, means.fast_avg, means.fast_valid);
         ring_mean(RING_MID,  now_ms, means.mid_avg,  means.mid_valid);
         ring_mean(RING_SLOW, now_ms, means.slow_avg, means.slow_valid);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_FAST_INTERVAL: take_interval[RING_FAST] = value[INTERVAL_W-1:0];
         CSR_MID_INTERVAL:  take_interval[RING_MID]  = value[INTERVAL_W-1:0];
         CSR_SLOW_INTERVAL: take_interval[RING_SLOW] = value[INTERVAL_W-1:0];
         CSR_FAST_WINDOW:   view_window[RING_FAST]   = value[WINDOW_W-1:0];
         CSR_MID_WINDOW:    view_window[RING_MID]    = value[WINDOW_W-1:0];
         CSR_SLOW_WINDOW:   view_window[RING_SLOW]   = value[WINDOW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_request(input stimulus_row_t row);
      bit            produces;
      window_means_t means;
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= row.mode;
      req_tdata  <= {row.now_ms, row.speed};
      do @(posedge clock); while (!req_tready);
      predict_request(row.mode, row.speed, row.now_ms, produces, means);
      if (produces)
         pending_means.push_back(row.check == CHECK_TYPED ? row.typed : means);
   endtask

   // hold off until every recompute has answered and the last add has settled
   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      stimulus_row_t row;
      int            pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            stream_ms += $urandom_range(0, 999);
         else if (pick < 70)
            stream_ms += $urandom_range(1000, 2500);
         else if (pick < 85)
            stream_ms += $urandom_range(2500, 40000);
         else if (pick < 95)
            stream_ms += $urandom_range(40000, 2000000);
         else if (pick < 98)
            stream_ms = $urandom;
         else
            stream_ms += 32'd65536000 + $urandom_range(0, 2000);   // tick counter laps
         row.mode = ($urandom_range(0, 4) == 0) ? MODE_RECOMPUTE : MODE_ADD;
         case ($urandom_range(0, 9))
            0:       row.speed = 16'hFFFF;
            1:       row.speed = 16'hFFFE;
            2:       row.speed = 16'h0000;
            default: row.speed = $urandom_range(0, 65535);
         endcase
         row.now_ms = stream_ms;
         row.check  = CHECK_PREDICTED;
         row.typed  = ALL_INVALID;
         send_request(row);
         if (i == count / 2)
            wait_for_idle();
      end
   endtask

   function automatic void check_field(input string name, input logic [AVG_W-1:0] want,
                                       input logic [AVG_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      window_means_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected response, expected none got data %h valids %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_means.pop_front();
            check_field("fast_avg",   want.fast_avg,   rsp_tdata[AVG_W-1:0]);
            check_field("mid_avg",    want.mid_avg,    rsp_tdata[2*AVG_W-1:AVG_W]);
            check_field("slow_avg",   want.slow_avg,   rsp_tdata[3*AVG_W-1:2*AVG_W]);
            check_field("fast_valid", want.fast_valid, rsp_tuser[RING_FAST]);
            check_field("mid_valid",  want.mid_valid,  rsp_tuser[RING_MID]);
            check_field("slow_valid", want.slow_valid, rsp_tuser[RING_SLOW]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int r = 0; r < NUM_RINGS; r++) begin
         ring_head[r]    = 0;
         ring_fill[r]    = 0;
         last_take_ms[r] = '0;
      end
      take_interval[RING_FAST] = FAST_INTERVAL_RST;
      take_interval[RING_MID]  = MID_INTERVAL_RST;
      take_interval[RING_SLOW] = SLOW_INTERVAL_RST;
      view_window[RING_FAST]   = FAST_WINDOW_RST;
      view_window[RING_MID]    = MID_WINDOW_RST;
      view_window[RING_SLOW]   = SLOW_WINDOW_RST;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(directed_rows[i]);
      stream_ms = directed_rows[DIRECTED_ROWS-1].now_ms;
      send_random(150);
      wait_for_idle();

      // fast and mid rings take every sample; fast window zero through masked upper bits; spare indexes dropped
      write_register(CSR_FAST_INTERVAL, '0);
      write_register(CSR_MID_INTERVAL, '0);
      write_register(CSR_SLOW_INTERVAL, 22'd250);
      write_register(CSR_FAST_WINDOW, 22'h3F0000);
      write_register(CSR_MID_WINDOW, 22'(WINDOW_MAX));
      write_register(CSR_SLOW_WINDOW, 22'h2A0005);
      write_register(CSR_SPARE_LO, 22'h3FFFFF);
      write_register(CSR_SPARE_HI, 22'h155555);
      send_random(120);
      wait_for_idle();

      write_register(CSR_FAST_INTERVAL, INTERVAL_MAX);
      write_register(CSR_MID_INTERVAL, INTERVAL_MAX);
      write_register(CSR_SLOW_INTERVAL, INTERVAL_MAX);
      write_register(CSR_FAST_WINDOW, 22'(WINDOW_MAX));
      write_register(CSR_MID_WINDOW, 22'(WINDOW_MAX));
      write_register(CSR_SLOW_WINDOW, 22'(WINDOW_MAX));
      send_random(100);
      wait_for_idle();

      write_register(CSR_FAST_INTERVAL, 22'($urandom_range(0, 60000)));
      write_register(CSR_MID_INTERVAL, 22'($urandom_range(0, 60000)));
      write_register(CSR_SLOW_INTERVAL, 22'($urandom_range(0, 60000)));
      write_register(CSR_FAST_WINDOW, 22'($urandom_range(0, 4000)));
      write_register(CSR_MID_WINDOW, 22'($urandom_range(0, 4000)));
      write_register(CSR_SLOW_WINDOW, 22'($urandom_range(0, 4000)));
      send_random(100);
      wait_for_idle();

      // back to power-on settings, no idling on either side
      idle_bursts = 1'b0;
      write_register(CSR_FAST_INTERVAL, FAST_INTERVAL_RST);
      write_register(CSR_MID_INTERVAL, MID_INTERVAL_RST);
      write_register(CSR_SLOW_INTERVAL, SLOW_INTERVAL_RST);
      write_register(CSR_FAST_WINDOW, 22'(FAST_WINDOW_RST));
      write_register(CSR_MID_WINDOW, 22'(MID_WINDOW_RST));
      write_register(CSR_SLOW_WINDOW, 22'(SLOW_WINDOW_RST));
      send_random(80);
      wait_for_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/srwa_pkg.sv
rtl/core/subsampled_ring_window_average.sv
rtl/core/srwa_checker.sv
sim/tb_subsampled_ring_window_average.sv
